[design/stbs_pkg.sv]
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared types and constants for the sorted table binary search block.
// ----------------------------------------------------------------------------
package stbs_pkg;

  localparam int unsigned DEPTH_DEFAULT = 1024;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned PROBES_W      = 4;

  // Saturation limit of the probe counter
  localparam logic [PROBES_W-1:0] PROBES_MAX = 4'd15;

  // Operation codes
  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_CLEAR  = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;

  // Command item
  typedef struct packed {
    logic [1:0]               op;
    logic signed [DATA_W-1:0] value;
  } cmd_t;

  // Result item
  typedef struct packed {
    logic                found;
    logic [PROBES_W-1:0] probes;
  } res_t;

  // Search sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_COMPARE,
    ST_FINISH
  } state_t;

endpackage

[design/sorted_table_binary_search_top.sv]
// ----------------------------------------------------------------------------
// sorted_table_binary_search_top
// Table of signed 32-bit entries with append, clear and binary search.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel (cmd_valid / cmd_stall / cmd) carries one item: append
//   cmd.value, clear the table, or search for cmd.value. Unused op codes are
//   dropped. Only a search returns an item on the result channel
//   (res_valid / res_stall / res) with found and the probe count.
//   Append and clear are handled in the idle state; the block is ready again next cycle.
//   Each search probe reads one table entry through the registered RAM
//   port (ISSUE state) and then compares it in the shared comparator
//   (COMPARE state); a search makes at most 11 probes for 1024 entries.
//   The result is then loaded into the output register from FINISH.
//   cmd_stall is high while a search runs. A finished result sits in the
//   output register; the next item is accepted while it waits. If a second
//   search finishes while the register is still stalled, it holds in the
//   finish state until res_stall drops.
//   Reset (rst, synchronous) empties the table and drops any pending result;
//   table contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_top #(
  parameter int unsigned DEPTH = stbs_pkg::DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  stbs_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_stall,
  output stbs_pkg::res_t res
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  stbs_pkg::state_t state, state_next;

  logic [CW-1:0]                      count;
  logic [CW-1:0]                      base;
  logic [CW-1:0]                      n;
  logic signed [stbs_pkg::DATA_W-1:0] key;
  logic [stbs_pkg::PROBES_W-1:0]      probes;
  logic                               found;

  logic                          cmd_accept;
  logic                          wr_en;
  logic                          rd_en;
  logic                          load_res;
  logic [CW-1:0]                 half;
  logic [CW:0]                   probe_idx;
  logic [stbs_pkg::DATA_W-1:0]   rd_data;
  logic                          hit;
  logic                          less;
  logic [stbs_pkg::PROBES_W-1:0] probes_inc;

  assign cmd_accept = cmd_valid && !cmd_stall;

  // Probe position within the current window
  assign half      = (n - CW'(1)) >> 1;
  assign probe_idx = {1'b0, base} + {1'b0, half};

  // Shared comparator on the entry just read
  assign hit  = (rd_data == key);
  assign less = ($signed(rd_data) < key);

  assign probes_inc = (probes == stbs_pkg::PROBES_MAX) ? probes
                                                       : probes + 1'b1;

  stbs_ram #(
    .WIDTH (stbs_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[AW-1:0]),
    .wr_data (cmd.value),
    .rd_en   (rd_en),
    .rd_addr (probe_idx[AW-1:0]),
    .rd_data (rd_data)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      stbs_pkg::ST_IDLE: begin
        if (cmd_accept && cmd.op == stbs_pkg::OP_SEARCH) begin
          state_next = (count == '0) ? stbs_pkg::ST_FINISH : stbs_pkg::ST_ISSUE;
        end
      end
      stbs_pkg::ST_ISSUE: begin
        state_next = stbs_pkg::ST_COMPARE;
      end
      stbs_pkg::ST_COMPARE: begin
        if (hit || n == CW'(1)) begin
          state_next = stbs_pkg::ST_FINISH;
        end else begin
          state_next = stbs_pkg::ST_ISSUE;
        end
      end
      stbs_pkg::ST_FINISH: begin
        if (!res_valid || !res_stall) begin
          state_next = stbs_pkg::ST_IDLE;
        end
      end
      default: state_next = stbs_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    cmd_stall = 1'b1;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    load_res  = 1'b0;
    case (state)
      stbs_pkg::ST_IDLE: begin
        cmd_stall = 1'b0;
        wr_en     = cmd_valid && cmd.op == stbs_pkg::OP_APPEND
                    && count < CW'(DEPTH);
      end
      stbs_pkg::ST_ISSUE: begin
        rd_en = 1'b1;
      end
      stbs_pkg::ST_COMPARE: begin
        rd_en = 1'b0;
      end
      stbs_pkg::ST_FINISH: begin
        load_res = !res_valid || !res_stall;
      end
      default: cmd_stall = 1'b1;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stbs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Entry count: advance on append, drop on clear
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (wr_en) begin
      count <= count + 1'b1;
    end else if (cmd_accept && cmd.op == stbs_pkg::OP_CLEAR) begin
      count <= '0;
    end
  end

  // Search window, key and probe tally
  always_ff @(posedge clk) begin
    if (state == stbs_pkg::ST_IDLE) begin
      base   <= '0;
      n      <= count;
      key    <= cmd.value;
      probes <= '0;
      found  <= 1'b0;
    end else if (state == stbs_pkg::ST_COMPARE) begin
      probes <= probes_inc;
      found  <= hit;
      if (less) begin
        base <= probe_idx[CW-1:0] + 1'b1;
      end
      n <= n >> 1;
    end
  end

  // Output register: load on finish, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_res) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      res.found  <= found;
      res.probes <= probes;
    end
  end

`ifndef ASSERT_OFF
  // Entry count never passes the table size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above table size");

  // Every probe stays inside the filled part of the table
  a_probe_in_table: assert property (@(posedge clk) disable iff (rst)
    state == stbs_pkg::ST_ISSUE |-> probe_idx < {1'b0, count})
    else $error("probe index outside table");

  // A compare never runs on an empty window
  a_window_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == stbs_pkg::ST_COMPARE |-> n != '0)
    else $error("compare on empty window");

  // An accepted search starts probing or finishes at once
  a_search_start: assert property (@(posedge clk) disable iff (rst)
    cmd_accept && cmd.op == stbs_pkg::OP_SEARCH
    |=> state == stbs_pkg::ST_ISSUE || state == stbs_pkg::ST_FINISH)
    else $error("search did not start");

  // A pending result is never overwritten while stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |-> !load_res)
    else $error("result overwritten while stalled");
`endif

endmodule

[design/stbs_ram.sv]
// ----------------------------------------------------------------------------
// stbs_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module stbs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
